[design/pwmm_pkg.sv]
// shared types and constants for the pwm period and duty meter
package pwmm_pkg;

  localparam int CAPTURE_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [7:0] CFG_IDX_TIMEOUT = 8'd0;
  localparam logic [7:0] CFG_IDX_TICK_PS = 8'd1;

  localparam logic [23:0] TIMEOUT_RST = 24'd1000000;
  localparam logic [15:0] TICK_PS_RST = 16'd8333;

  localparam int FREQ_Q_BITS = 20;
  localparam int DUTY_Q_BITS = 17;

  localparam logic [19:0] FREQ_MAX = 20'd999999;
  localparam logic [16:0] DUTY_MAX = 17'd99999;
  localparam logic [19:0] DUTY_SCALE = 20'd100000;
  localparam logic [36:0] FREQ_NUM = 37'd100000000000;
  // a denominator at or below this gives a frequency that saturates
  localparam logic [16:0] FREQ_SAT_DEN = 17'd100000;
  // x / 10 as (x * DIV10_MUL) >> DIV10_SHIFT, exact below 2^22
  localparam logic [19:0] DIV10_MUL = 20'd838861;
  localparam int DIV10_SHIFT = 23;

  typedef enum logic [1:0] {
    KIND_RISE   = 2'd0,
    KIND_FALL   = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_REPORT = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULD,
    S_MULH,
    S_DIVF,
    S_CHKD,
    S_DIVD,
    S_MUL10,
    S_SUM,
    S_BCDF,
    S_BCDD,
    S_OUT
  } state_e;

endpackage

[design/pwm_period_duty_meter_top.sv]
// pwm period and duty meter: capture tracking, shared divider and bcd sequencer
//
// Input channel s_axis: tuser carries the kind (rising capture, falling capture,
// idle tick, report request) and tdata the 16-bit timer capture. Captures and
// idle ticks update the meter state in the cycle they are accepted and give no
// result. A report request gives one beat on m_axis with frequency (10 Hz units),
// duty (thousandths of a percent) and their bcd digits; tuser flags no signal.
// The cfg channel writes timeout_limit (index 0) and tick_period_ps (index 1);
// it is always ready and is to be written only while the meter is idle.
// A report with a valid signal uses one shared multiplier and one shared restoring
// divider (one quotient bit per cycle, 20 bits for the frequency, 17 for the duty;
// a division whose result saturates is skipped) followed by a shift-add-3 bcd
// converter that reuses the divider's shift register.
// A timeout or zero-period report skips the arithmetic.
// s_axis_tready is low while a report is being worked on. The result sits in an
// output register, so a stalled receiver only holds the next report at its last
// step. Reset clears the meter state, restores the register defaults and drops
// any pending result.
module pwm_period_duty_meter_top #(
  parameter int CAPTURE_BITS = pwmm_pkg::CAPTURE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] capture_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [19:0] freq_tens_hz, [36:20] duty_milli_pct,
                                      // [60:37] freq_bcd, [72:61] duty_bcd, [79:73] zero
  output logic        m_axis_tuser,   // [0] no_signal
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import pwmm_pkg::*;

  localparam int CB     = CAPTURE_BITS;
  localparam int DEN_W  = CB + 16;
  localparam int MA_W   = (CB > FREQ_Q_BITS) ? CB : FREQ_Q_BITS;
  localparam int MB_W   = 20;
  localparam int PROD_W = MA_W + MB_W;
  localparam int HP_W   = CB + DUTY_Q_BITS;

  state_e state_q, state_d;

  logic [23:0]   tmo_limit_q;
  logic [15:0]   tick_ps_q;
  logic [CB-1:0] last_rise_q, period_q, high_q;
  logic [23:0]   rise_idle_q, fall_idle_q;

  logic [DEN_W-1:0] den_q;
  logic [HP_W-1:0]  hprod_q;
  logic [DEN_W-1:0] rem_q;
  logic [19:0]      dq_q;
  logic [4:0]       cnt_q;
  logic [19:0]      freq_q;
  logic [16:0]      duty_q, f10_q;
  logic             nosig_q;
  logic [23:0]      bcd_q, fbcd_q;
  logic [11:0]      dbcd_q;

  logic        ov_q;
  logic [79:0] odata_q;
  logic        ouser_q;

  logic          in_fire;
  kind_e         kind;
  logic [CB-1:0] cap;
  logic          rep_tmo, rep_zero, rep_start;
  logic          last_step, out_load;

  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod;

  logic [DEN_W-1:0] div_den;
  logic [DEN_W:0]   div_wide, div_diff;
  logic             div_ge;
  logic [DEN_W-1:0] rem_nx;
  logic [19:0]      dq_nx;

  logic [23:0] bcd_adj, bcd_nx;
  logic [19:0] dd_nx;
  logic [17:0] duty_sum;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign kind          = kind_e'(s_axis_tuser);
  assign cap           = CB'(s_axis_tdata);
  assign cfg_ready_o   = 1'b1;

  assign rep_tmo   = (rise_idle_q > tmo_limit_q) || (fall_idle_q > tmo_limit_q);
  assign rep_zero  = (period_q == '0) || (tick_ps_q == '0);
  assign rep_start = in_fire && (kind == KIND_REPORT);
  assign last_step = (cnt_q == 5'd1);
  assign out_load  = (state_q == S_OUT) && (!ov_q || m_axis_tready);

  // shared multiplier
  always_comb begin
    unique case (state_q)
      S_MULH: begin
        mul_a = MA_W'(high_q);
        mul_b = DUTY_SCALE;
      end
      S_MUL10: begin
        mul_a = MA_W'(freq_q);
        mul_b = DIV10_MUL;
      end
      default: begin
        mul_a = MA_W'(period_q);
        mul_b = MB_W'(tick_ps_q);
      end
    endcase
  end
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // restoring divider step, one quotient bit per cycle
  assign div_den  = (state_q == S_DIVF) ? den_q : DEN_W'(period_q);
  assign div_wide = {rem_q, dq_q[19]};
  assign div_ge   = div_wide >= {1'b0, div_den};
  assign div_diff = div_wide - {1'b0, div_den};
  assign rem_nx   = div_ge ? div_diff[DEN_W-1:0] : div_wide[DEN_W-1:0];
  assign dq_nx    = {dq_q[18:0], div_ge};

  // shift-add-3 step over six digits
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                   : bcd_q[4*i +: 4];
    end
  end
  assign bcd_nx = {bcd_adj[22:0], dq_q[19]};
  assign dd_nx  = {dq_q[18:0], 1'b0};

  assign duty_sum = {1'b0, duty_q} + {1'b0, f10_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (rep_start) begin
          state_d = (rep_tmo || rep_zero) ? S_BCDF : S_MULD;
        end
      end
      S_MULD:  state_d = S_MULH;
      S_MULH:  state_d = (den_q <= DEN_W'(FREQ_SAT_DEN)) ? S_CHKD : S_DIVF;
      S_DIVF:  if (last_step) state_d = S_CHKD;
      S_CHKD:  state_d = (high_q >= period_q) ? S_MUL10 : S_DIVD;
      S_DIVD:  if (last_step) state_d = S_MUL10;
      S_MUL10: state_d = S_SUM;
      S_SUM:   state_d = S_BCDF;
      S_BCDF:  if (last_step) state_d = S_BCDD;
      S_BCDD:  if (last_step) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration and meter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_limit_q <= TIMEOUT_RST;
      tick_ps_q   <= TICK_PS_RST;
      last_rise_q <= '0;
      period_q    <= '0;
      high_q      <= '0;
      rise_idle_q <= '0;
      fall_idle_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_IDX_TIMEOUT) begin
          tmo_limit_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_IDX_TICK_PS) begin
          tick_ps_q <= cfg_data_i[15:0];
        end
      end
      if (in_fire) begin
        unique case (kind)
          KIND_RISE: begin
            period_q    <= cap - last_rise_q;
            last_rise_q <= cap;
            rise_idle_q <= '0;
          end
          KIND_FALL: begin
            high_q      <= cap - last_rise_q;
            fall_idle_q <= '0;
          end
          KIND_TICK: begin
            if (rise_idle_q != '1) rise_idle_q <= rise_idle_q + 24'd1;
            if (fall_idle_q != '1) fall_idle_q <= fall_idle_q + 24'd1;
          end
          KIND_REPORT: ;
          default: ;
        endcase
      end
    end
  end

  // report datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (rep_start) begin
          nosig_q <= rep_tmo || rep_zero;
          freq_q  <= '0;
          duty_q  <= (rep_tmo && (rise_idle_q < fall_idle_q)) ? DUTY_MAX : '0;
          dq_q    <= '0;
          bcd_q   <= '0;
          cnt_q   <= 5'(FREQ_Q_BITS);
        end
      end
      S_MULD: begin
        den_q <= prod[DEN_W-1:0];
      end
      S_MULH: begin
        hprod_q <= prod[HP_W-1:0];
        if (den_q <= DEN_W'(FREQ_SAT_DEN)) begin
          freq_q <= FREQ_MAX;
        end else begin
          // top quotient bits are known zero, start with the upper dividend in rem
          rem_q <= DEN_W'(FREQ_NUM[36:FREQ_Q_BITS]);
          dq_q  <= FREQ_NUM[FREQ_Q_BITS-1:0];
          cnt_q <= 5'(FREQ_Q_BITS);
        end
      end
      S_DIVF: begin
        rem_q <= rem_nx;
        dq_q  <= dq_nx;
        cnt_q <= cnt_q - 5'd1;
        if (last_step) freq_q <= dq_nx;
      end
      S_CHKD: begin
        if (high_q >= period_q) begin
          duty_q <= DUTY_MAX;
        end else begin
          rem_q <= DEN_W'(hprod_q[HP_W-1:DUTY_Q_BITS]);
          dq_q  <= {hprod_q[DUTY_Q_BITS-1:0], 3'b000};
          cnt_q <= 5'(DUTY_Q_BITS);
        end
      end
      S_DIVD: begin
        rem_q <= rem_nx;
        dq_q  <= dq_nx;
        cnt_q <= cnt_q - 5'd1;
        if (last_step) duty_q <= dq_nx[DUTY_Q_BITS-1:0];
      end
      S_MUL10: begin
        f10_q <= prod[DIV10_SHIFT+16:DIV10_SHIFT];
      end
      S_SUM: begin
        duty_q <= (duty_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : duty_sum[16:0];
        dq_q   <= freq_q;
        bcd_q  <= '0;
        cnt_q  <= 5'(FREQ_Q_BITS);
      end
      S_BCDF: begin
        if (last_step) begin
          fbcd_q <= bcd_nx;
          bcd_q  <= '0;
          dq_q   <= {duty_q, 3'b000};
          cnt_q  <= 5'(DUTY_Q_BITS);
        end else begin
          bcd_q <= bcd_nx;
          dq_q  <= dd_nx;
          cnt_q <= cnt_q - 5'd1;
        end
      end
      S_BCDD: begin
        bcd_q <= bcd_nx;
        dq_q  <= dd_nx;
        cnt_q <= cnt_q - 5'd1;
        // percent tens, units and tenths are the upper three of five digits
        if (last_step) dbcd_q <= bcd_nx[19:8];
      end
      S_OUT: begin
        if (out_load) begin
          odata_q <= {7'd0, dbcd_q, fbcd_q, duty_q, freq_q};
          ouser_q <= nosig_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (m_axis_tready) begin
      ov_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

endmodule

[verif/tb_pwm_period_duty_meter_top.sv]
// testbench for the pwm period and duty meter: directed and random capture streams
module tb_pwm_period_duty_meter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pwmm_pkg::*;

  localparam logic [7:0]       CFG_IDX_FIRST_UNUSED = 8'd2;
  localparam logic [23:0]      IDLE_SAT = 24'hFFFFFF;
  localparam longint unsigned  TENS_HZ_NUMERATOR = 64'd100000000000;
  localparam int               SETTLE_CYCLES = 120;
  localparam int               PHASE_ITEMS = 260;
  localparam int               LONG_HOLD_CYCLES = 600;

  typedef struct {
    logic [19:0] freq_tens_hz;
    logic [16:0] duty_milli_pct;
    logic [23:0] freq_bcd;
    logic [11:0] duty_bcd;
    logic        no_signal;
  } meter_result_t;

  // mirror of the meter: capture tracking, idle counters and report arithmetic
  class meter_scoreboard;
    logic [23:0]   timeout_lim;
    logic [15:0]   tick_ps;
    logic [15:0]   rise_ref;
    logic [15:0]   period_cnt;
    logic [15:0]   high_cnt;
    logic [23:0]   rise_idle;
    logic [23:0]   fall_idle;
    meter_result_t reports_q[$];
    int            errors;

    function new();
      timeout_lim = TIMEOUT_RST;
      tick_ps     = TICK_PS_RST;
      rise_ref    = '0;
      period_cnt  = '0;
      high_cnt    = '0;
      rise_idle   = '0;
      fall_idle   = '0;
      errors      = 0;
    endfunction

    function int pending();
      return reports_q.size();
    endfunction

    function logic [23:0] to_bcd(longint unsigned v, int digits);
      logic [23:0] bcd_val;
      bcd_val = '0;
      for (int i = 0; i < digits; i++) begin
        bcd_val[4*i +: 4] = 4'(v % 10);
        v = v / 10;
      end
      return bcd_val;
    endfunction

    function void write_config(logic [7:0] idx, logic [23:0] val);
      if (idx == CFG_IDX_TIMEOUT) timeout_lim = val;
      else if (idx == CFG_IDX_TICK_PS) tick_ps = val[15:0];
    endfunction

    function void note_input(kind_e kind, logic [15:0] cap);
      meter_result_t   res;
      longint unsigned den;
      longint unsigned freq;
      longint unsigned duty;
      case (kind)
        KIND_RISE: begin
          period_cnt = cap - rise_ref;
          rise_ref   = cap;
          rise_idle  = '0;
        end
        KIND_FALL: begin
          high_cnt  = cap - rise_ref;
          fall_idle = '0;
        end
        KIND_TICK: begin
          if (rise_idle != IDLE_SAT) rise_idle = rise_idle + 24'd1;
          if (fall_idle != IDLE_SAT) fall_idle = fall_idle + 24'd1;
        end
        default: begin
          freq = 0;
          duty = 0;
          res.no_signal = 1'b0;
          if (rise_idle > timeout_lim || fall_idle > timeout_lim) begin
            res.no_signal = 1'b1;
            // the edge that went quiet first decides whether the line sits high or low
            duty = (rise_idle < fall_idle) ? 64'(DUTY_MAX) : 0;
          end else if (period_cnt == 0 || tick_ps == 0) begin
            res.no_signal = 1'b1;
          end else begin
            den  = 64'(period_cnt) * 64'(tick_ps);
            freq = TENS_HZ_NUMERATOR / den;
            if (freq > FREQ_MAX) freq = FREQ_MAX;
            duty = (64'(high_cnt) * 64'(DUTY_SCALE)) / 64'(period_cnt) + freq / 10;
            if (duty > DUTY_MAX) duty = DUTY_MAX;
          end
          res.freq_tens_hz   = freq[19:0];
          res.duty_milli_pct = duty[16:0];
          res.freq_bcd       = to_bcd(freq, 6);
          res.duty_bcd       = 12'(to_bcd(duty / 100, 3));
          reports_q.push_back(res);
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task check_result(logic [79:0] beat, logic flag);
      meter_result_t want;
      if (reports_q.size() == 0) begin
        report_mismatch($sformatf("result beat %h with no report outstanding", beat));
        return;
      end
      want = reports_q.pop_front();
      if (beat[19:0] !== want.freq_tens_hz)
        report_mismatch($sformatf("freq_tens_hz got %0d expected %0d",
                                  beat[19:0], want.freq_tens_hz));
      if (beat[36:20] !== want.duty_milli_pct)
        report_mismatch($sformatf("duty_milli_pct got %0d expected %0d",
                                  beat[36:20], want.duty_milli_pct));
      if (beat[60:37] !== want.freq_bcd)
        report_mismatch($sformatf("freq_bcd got %h expected %h", beat[60:37], want.freq_bcd));
      if (beat[72:61] !== want.duty_bcd)
        report_mismatch($sformatf("duty_bcd got %h expected %h", beat[72:61], want.duty_bcd));
      if (beat[79:73] !== '0)
        report_mismatch($sformatf("tdata padding got %h expected zero", beat[79:73]));
      if (flag !== want.no_signal)
        report_mismatch($sformatf("no_signal got %b expected %b", flag, want.no_signal));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = KIND_RISE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = CFG_IDX_TIMEOUT;
  logic [23:0] cfg_data_i = '0;

  meter_scoreboard meter_sb = new();
  int items_sent  = 0;
  int tx_gap_pct  = 15;
  int rx_stall_pct = 15;
  bit hold_req    = 1'b0;

  pwm_period_duty_meter_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_item(kind_e kind, logic [15:0] cap);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= cap;
    do @(posedge clk_i); while (!s_axis_tready);
    meter_sb.note_input(kind, cap);
    items_sent++;
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    meter_sb.write_config(idx, val);
  endtask

  // an unused index goes in between, it must leave both registers alone
  task automatic configure(logic [23:0] limit, logic [15:0] tick);
    cfg_write(CFG_IDX_TIMEOUT, limit);
    cfg_write(8'($urandom_range(CFG_IDX_FIRST_UNUSED, 255)), 24'($urandom));
    cfg_write(CFG_IDX_TICK_PS, {8'($urandom), tick});
    cfg_valid_i <= 1'b0;
  endtask

  // wait out every report, then the tail of any report still being worked on
  task automatic settle_meter();
    s_axis_tvalid <= 1'b0;
    while (meter_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) meter_sb.check_result(m_axis_tdata, m_axis_tuser);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        stall_left = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int          phase_end;
    int          pick;
    int          span;
    int          high_span;
    int          tick_reach;
    logic [15:0] stamp;
    logic [23:0] cur_limit;
    logic [15:0] cur_tick;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(KIND_REPORT, 16'h0000);   // nothing measured yet
    send_item(KIND_RISE, 16'h0000);
    send_item(KIND_RISE, 16'h0000);     // equal captures give a zero period
    send_item(KIND_REPORT, 16'hFFFF);
    send_item(KIND_RISE, 16'hFFFF);     // longest period
    send_item(KIND_FALL, 16'hFFFF);     // zero high time
    send_item(KIND_REPORT, 16'h0000);
    send_item(KIND_RISE, 16'h0000);     // one tick across the wrap, frequency saturates
    send_item(KIND_FALL, 16'h0000);
    send_item(KIND_REPORT, 16'h0000);
    send_item(KIND_RISE, 16'h8000);
    send_item(KIND_FALL, 16'h0000);     // high time wraps round to equal the period, duty saturates
    send_item(KIND_REPORT, 16'h5555);
    send_item(KIND_FALL, 16'hC000);
    send_item(KIND_TICK, 16'hAAAA);
    send_item(KIND_TICK, 16'hFFFF);
    send_item(KIND_REPORT, 16'h0000);
    send_item(KIND_RISE, 16'h8064);
    send_item(KIND_FALL, 16'h8096);
    send_item(KIND_REPORT, 16'h0000);

    stamp = 16'($urandom);
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin cur_limit = TIMEOUT_RST; cur_tick = TICK_PS_RST; end
        1: begin
          cur_limit = '0; cur_tick = 16'd1;
          tx_gap_pct = 30; rx_stall_pct = 10;
        end
        2: begin
          cur_limit = IDLE_SAT; cur_tick = 16'hFFFF;
          tx_gap_pct = 0; rx_stall_pct = 0;
        end
        3: begin
          cur_limit = 24'd6; cur_tick = TICK_PS_RST;
          tx_gap_pct = 10; rx_stall_pct = 30;
        end
        4: begin
          cur_limit = 24'd3; cur_tick = '0;
          tx_gap_pct = 20; rx_stall_pct = 20;
        end
        5: begin
          cur_limit = 24'($urandom_range(0, 20)); cur_tick = 16'($urandom_range(1, 65535));
          tx_gap_pct = 40; rx_stall_pct = 40;
        end
        default: begin
          cur_limit = TIMEOUT_RST; cur_tick = 16'($urandom_range(1000, 20000));
          tx_gap_pct = 0; rx_stall_pct = 0;
        end
      endcase
      if (phase > 0) begin
        settle_meter();
        configure(cur_limit, cur_tick);
      end
      // receiver goes quiet while reports keep coming, so the input backs up
      if (phase == 3) hold_req = 1'b1;
      tick_reach = (cur_limit < 22) ? int'(cur_limit) + 3 : 3;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          // one pwm cycle: rise, fall, some idle ticks, maybe a report
          case ($urandom_range(0, 9))
            0, 1, 2, 3: span = $urandom_range(1, 300);
            4, 5, 6:    span = $urandom_range(301, 5000);
            7, 8:       span = $urandom_range(5001, 65535);
            default: begin
              case ($urandom_range(0, 3))
                0:       span = 0;
                1:       span = 1;
                2:       span = 65535;
                default: span = 32768;
              endcase
            end
          endcase
          high_span = $urandom_range(0, span);
          send_item(KIND_RISE, stamp);
          send_item(KIND_FALL, 16'(stamp + high_span));
          repeat (($urandom_range(0, 3) == 0) ? $urandom_range(0, tick_reach)
                                              : $urandom_range(0, 2))
            send_item(KIND_TICK, 16'($urandom));
          stamp = 16'(stamp + span);
          if ($urandom_range(0, 1) == 1) send_item(KIND_REPORT, 16'($urandom));
        end else if (pick <= 8) begin
          repeat ($urandom_range(1, 4)) send_item(kind_e'($urandom_range(0, 3)), 16'($urandom));
        end else begin
          // broken cycle: a stray edge straight into a report
          if ($urandom_range(0, 1) == 1) send_item(KIND_FALL, 16'($urandom));
          else send_item(KIND_RISE, stamp);
          send_item(KIND_REPORT, 16'($urandom));
        end
      end
    end

    settle_meter();
    if (meter_sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
